// ===== rtl/autoscaled_scope_trace_unit_defines.svh =====
// assertion macros for the scope trace unit
`ifndef AUTOSCALED_SCOPE_TRACE_UNIT_DEFINES_SVH
`define AUTOSCALED_SCOPE_TRACE_UNIT_DEFINES_SVH

// same-cycle implication
`define AST_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define AST_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/ast_pkg.sv =====
package ast_pkg;

  localparam int OP_W      = 2;
  localparam int IDX_W     = 7;
  localparam int COORD_W   = 10;
  localparam int HGT_W     = 11;
  localparam int X_W       = 11;
  localparam int Y_W       = 12;
  localparam int CFG_IDX_W = 2;

  typedef logic [COORD_W-1:0] coord_t;
  typedef logic [Y_W-1:0]     y_t;

  localparam logic [OP_W-1:0] OP_ADD   = 2'd0;
  localparam logic [OP_W-1:0] OP_PLOT  = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_WIN_LEFT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WIN_TOP    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WIN_RIGHT  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WIN_BOTTOM = 2'd3;

  localparam coord_t WIN_LEFT_RST   = 10'd0;
  localparam coord_t WIN_TOP_RST    = 10'd0;
  localparam coord_t WIN_RIGHT_RST  = 10'd127;
  localparam coord_t WIN_BOTTOM_RST = 10'd63;

endpackage

// ===== rtl/ast_serial_div.sv =====
module ast_serial_div #(
  parameter int DW = 16,
  parameter int QB = 11
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DW+QB-1:0] num,
  input  logic [DW-1:0]    den,
  output logic             done,
  output logic [QB-1:0]    quo
);

  localparam int CNT_W = $clog2(QB + 1);

  logic [DW-1:0]    rem;
  logic [QB-1:0]    nlo;
  logic [CNT_W-1:0] cnt;
  logic [DW:0]      trial;
  logic             fits;

  // one quotient bit per cycle
  assign trial = {rem, nlo[QB-1]};
  assign fits  = trial >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        cnt <= CNT_W'(QB);
      end else if (cnt != '0) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= num[DW+QB-1:QB];
      nlo <= num[QB-1:0];
    end else if (cnt != '0) begin
      rem <= fits ? DW'(trial - {1'b0, den}) : trial[DW-1:0];
      nlo <= {nlo[QB-2:0], 1'b0};
      quo <= {quo[QB-2:0], fits};
    end
  end

endmodule

// ===== rtl/autoscaled_scope_trace_unit.sv =====
// autoscaled scope trace unit
// command channel: an item is taken on a rising edge with start high and busy
// low; opcode selects add sample, plot query or clear, sample and point_index
// travel with it. busy stays high until the result has been shown.
// result channel: done is high for exactly one cycle per item, with
// latest_value, point_valid, joins_previous, point_x, point_y and zero_line_y
// valid in that cycle. the receiver cannot stall, so the result is lost if
// not taken in that cycle.
// sequence: each item passes the states read, multiply, divider start,
// divider wait and output; the next item can be taken in the cycle after
// done, not before. the bit-serial dividers (one quotient bit per cycle,
// 11 bits) scale point and zero line in parallel.
// configuration: cfg_we writes cfg_data into window register cfg_index at
// once; write only while busy is low.
// reset (rst, synchronous): window registers to 0, 0, 127, 63, trace empty,
// min, max and latest value zero. the sample store is not cleared; only
// entries written since the last clear reach a valid point.
module autoscaled_scope_trace_unit #(
  parameter int DEPTH       = 128,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  output logic                                 busy,
  input  logic [ast_pkg::OP_W-1:0]             opcode,
  input  logic signed [SAMPLE_BITS-1:0]        sample,
  input  logic [ast_pkg::IDX_W-1:0]            point_index,
  input  logic                                 cfg_we,
  input  logic [ast_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [ast_pkg::COORD_W-1:0]          cfg_data,
  output logic                                 done,
  output logic signed [SAMPLE_BITS-1:0]        latest_value,
  output logic                                 point_valid,
  output logic                                 joins_previous,
  output logic [ast_pkg::X_W-1:0]              point_x,
  output logic signed [ast_pkg::Y_W-1:0]       point_y,
  output logic signed [ast_pkg::Y_W-1:0]       zero_line_y
);

  localparam int SB  = SAMPLE_BITS;
  localparam int HW  = ast_pkg::HGT_W;
  localparam int NW  = SB + HW;
  localparam int AW  = $clog2(DEPTH);
  localparam int FW  = $clog2(DEPTH + 1);
  localparam int CW  = (FW > HW) ? FW : HW;
  localparam int PW  = ((AW > ast_pkg::IDX_W) ? AW : ast_pkg::IDX_W) + 2;
  localparam int YW  = ast_pkg::Y_W;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_READ = 3'd1;
  localparam logic [2:0] S_MUL  = 3'd2;
  localparam logic [2:0] S_DIVS = 3'd3;
  localparam logic [2:0] S_DIVW = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;

  ast_pkg::coord_t win_left;
  ast_pkg::coord_t win_top;
  ast_pkg::coord_t win_right;
  ast_pkg::coord_t win_bottom;

  logic signed [SB-1:0] store [DEPTH];
  logic [AW-1:0]        write_pos;
  logic [AW-1:0]        newest_pos;
  logic [FW-1:0]        fill_count;
  logic signed [SB-1:0] run_min;
  logic signed [SB-1:0] run_max;
  logic signed [SB-1:0] last_sample;
  logic                 first_pending;

  logic [ast_pkg::OP_W-1:0]  op_r;
  logic [ast_pkg::IDX_W-1:0] k_r;
  logic signed [SB-1:0]      rd_data;
  logic                      valid_r;
  logic [ast_pkg::X_W-1:0]   x_r;
  logic [NW-1:0]             num_p;
  logic [NW-1:0]             num_z;
  logic [SB-1:0]             range_r;
  ast_pkg::y_t               py_r;
  ast_pkg::y_t               zy_r;

  logic                 acc;
  logic [HW-1:0]        hgt;
  logic [HW-1:0]        wraw;
  logic [CW-1:0]        wid;
  logic [CW-1:0]        kx;
  logic [PW-1:0]        pos_sum;
  logic [AW-1:0]        rd_pos;
  logic signed [SB-1:0] zc;
  logic [SB-1:0]        pdiff;
  logic [SB-1:0]        zdiff;
  logic [CW:0]          x_full;
  ast_pkg::y_t          y_base;
  logic                 div_start;
  logic                 done_p;
  logic                 done_z;
  logic [HW-1:0]        quo_p;
  logic [HW-1:0]        quo_z;

  assign busy = state != S_IDLE;
  assign acc  = start && !busy;

  // window geometry
  assign hgt  = HW'(1) + ((win_bottom >= win_top) ? HW'(win_bottom - win_top)
                                                   : HW'(win_top - win_bottom));
  assign wraw = HW'(1) + ((win_right >= win_left) ? HW'(win_right - win_left)
                                                   : HW'(win_left - win_right));
  assign wid  = (CW'(wraw) > CW'(DEPTH)) ? CW'(DEPTH) : CW'(wraw);
  assign kx   = CW'(k_r);

  // ring position of the k-th newest sample
  assign pos_sum = PW'(newest_pos) + PW'(DEPTH) - PW'(k_r);
  assign rd_pos  = (pos_sum >= PW'(DEPTH)) ? AW'(pos_sum - PW'(DEPTH)) : AW'(pos_sum);

  // zero clamped into min..max
  always_comb begin
    zc = '0;
    if (run_min > zc) begin
      zc = run_min;
    end else if (run_max < zc) begin
      zc = run_max;
    end
  end

  assign pdiff  = rd_data - run_min;
  assign zdiff  = zc - run_min;
  assign x_full = (CW + 1)'(win_left) + (CW + 1)'(wid) - (CW + 1)'(1) - (CW + 1)'(kx);
  assign y_base = YW'(win_top) + YW'(hgt) - YW'(1);
  assign div_start = state == S_DIVS;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (acc) begin
          state_next = S_READ;
        end
      end
      S_READ: state_next = S_MUL;
      S_MUL:  state_next = S_DIVS;
      S_DIVS: state_next = S_DIVW;
      S_DIVW: begin
        if (done_p && done_z) begin
          state_next = S_OUT;
        end
      end
      S_OUT:  state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // window registers
  always_ff @(posedge clk) begin
    if (rst) begin
      win_left   <= ast_pkg::WIN_LEFT_RST;
      win_top    <= ast_pkg::WIN_TOP_RST;
      win_right  <= ast_pkg::WIN_RIGHT_RST;
      win_bottom <= ast_pkg::WIN_BOTTOM_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        ast_pkg::REG_WIN_LEFT:   win_left   <= cfg_data;
        ast_pkg::REG_WIN_TOP:    win_top    <= cfg_data;
        ast_pkg::REG_WIN_RIGHT:  win_right  <= cfg_data;
        ast_pkg::REG_WIN_BOTTOM: win_bottom <= cfg_data;
        default: ;
      endcase
    end
  end

  // trace state
  always_ff @(posedge clk) begin
    if (rst) begin
      write_pos     <= '0;
      newest_pos    <= '0;
      fill_count    <= '0;
      run_min       <= '0;
      run_max       <= '0;
      last_sample   <= '0;
      first_pending <= 1'b1;
    end else if (acc) begin
      case (opcode)
        ast_pkg::OP_ADD: begin
          last_sample <= sample;
          if (first_pending || sample < run_min) begin
            run_min <= sample;
          end
          if (first_pending || sample > run_max) begin
            run_max <= sample;
          end
          first_pending <= 1'b0;
          newest_pos    <= write_pos;
          write_pos     <= (write_pos == AW'(DEPTH - 1)) ? '0 : write_pos + 1'b1;
          if (fill_count < FW'(DEPTH)) begin
            fill_count <= fill_count + 1'b1;
          end
        end
        ast_pkg::OP_CLEAR: begin
          write_pos     <= '0;
          newest_pos    <= '0;
          fill_count    <= '0;
          run_min       <= '0;
          run_max       <= '0;
          last_sample   <= '0;
          first_pending <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  // sample store
  always_ff @(posedge clk) begin
    if (acc && opcode == ast_pkg::OP_ADD) begin
      store[write_pos] <= sample;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_READ) begin
      rd_data <= store[rd_pos];
    end
  end

  // item datapath
  always_ff @(posedge clk) begin
    if (acc) begin
      op_r <= opcode;
      k_r  <= point_index;
    end
    if (state == S_READ) begin
      valid_r <= (op_r == ast_pkg::OP_PLOT) && (kx < wid) && (kx < CW'(fill_count));
      x_r     <= x_full[ast_pkg::X_W-1:0];
    end
    if (state == S_MUL) begin
      num_p   <= NW'(pdiff) * NW'(hgt);
      num_z   <= NW'(zdiff) * NW'(hgt);
      range_r <= run_max - run_min;
    end
    if (state == S_DIVW && done_p) begin
      if (range_r == '0) begin
        py_r <= YW'(win_top);
        zy_r <= YW'(win_top);
      end else begin
        py_r <= y_base - YW'(quo_p);
        zy_r <= y_base - YW'(quo_z);
      end
    end
  end

  ast_serial_div #(.DW(SB), .QB(HW)) u_div_point (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (num_p),
    .den   (range_r),
    .done  (done_p),
    .quo   (quo_p)
  );

  ast_serial_div #(.DW(SB), .QB(HW)) u_div_zero (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (num_z),
    .den   (range_r),
    .done  (done_z),
    .quo   (quo_z)
  );

  assign done           = state == S_OUT;
  assign latest_value   = last_sample;
  assign point_valid    = valid_r;
  assign joins_previous = valid_r && (k_r != '0);
  assign point_x        = valid_r ? x_r : '0;
  assign point_y        = valid_r ? py_r : '0;
  assign zero_line_y    = zy_r;

endmodule

// ===== rtl/ast_checker.sv =====
`include "autoscaled_scope_trace_unit_defines.svh"

module ast_checker (
  input logic                                 clk,
  input logic                                 rst,
  input logic                                 start,
  input logic                                 busy,
  input logic                                 done,
  input logic                                 point_valid,
  input logic                                 joins_previous,
  input logic [ast_pkg::X_W-1:0]              point_x,
  input logic signed [ast_pkg::Y_W-1:0]       point_y
);

  `AST_ASSERT_NEXT(a_take_busy, start && !busy, busy, "accepted item did not raise busy")
  `AST_ASSERT_NOW(a_done_busy, done, busy, "result shown while idle")
  `AST_ASSERT_NEXT(a_done_free, done, !busy && !done, "block not free after result")
  `AST_ASSERT_NOW(a_join_valid, done && joins_previous, point_valid, "join without valid point")
  `AST_ASSERT_NOW(a_invalid_zero, done && !point_valid, point_x == '0 && point_y == '0, "invalid point carries coordinates")

endmodule

bind autoscaled_scope_trace_unit ast_checker u_ast_checker (
  .clk            (clk),
  .rst            (rst),
  .start          (start),
  .busy           (busy),
  .done           (done),
  .point_valid    (point_valid),
  .joins_previous (joins_previous),
  .point_x        (point_x),
  .point_y        (point_y)
);
